>>> hw/rtl/qdv_pkg.sv
// Shared types, constants and the quadrature step decode for the decoder.
`timescale 1ns / 1ps
`default_nettype none

package qdv_pkg;

   // Field and datapath widths
   localparam int REG_W      = 31;
   localparam int TS_W       = 63;
   localparam int OUT_W      = 32;
   localparam int MAG_W      = 34;
   localparam int MAG_HALF_W = MAG_W / 2;
   localparam int NS_W       = 30;
   localparam int PART_W     = MAG_HALF_W + NS_W;
   localparam int PROD_W     = 64;
   localparam int CNT_W      = $clog2(PROD_W);
   localparam int CSR_IDX_W  = 1;

   // Arithmetic constants
   localparam logic [NS_W-1:0]   NS_PER_SEC   = 30'd1000000000;
   localparam logic [PROD_W-1:0] MAG_LIMIT    = 64'd9223372036;
   localparam logic [PROD_W-1:0] POS_LIMIT    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [OUT_W-1:0]  VEL_POS_MAX  = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0]  VEL_NEG_MAX  = 32'h8000_0000;
   localparam logic [REG_W-1:0]  MIN_INTERVAL_RESET = 31'd1000000;
   localparam logic [REG_W-1:0]  MAX_GAP_RESET      = 31'd2000000000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP      = 1'b1;

   // Opcodes
   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_UP,
      STEP_DOWN
   } step_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_in;
      logic calc;
      logic mul_lo;
      logic mul_hi;
      logic div_step;
      logic sat;
      logic load_rsp;
   } ctrl_cmd_type;

   // Commands to the multiply and divide unit
   typedef struct packed {
      logic mul_lo;
      logic mul_hi;
      logic step;
   } div_cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic update;
      logic div_last;
   } dp_status_type;

   // Transition table: rows are the old phase bits, columns the new ones
   function automatic step_type qdv_step(input logic [1:0] prev, input logic [1:0] cur);
      step_type s;
      unique case ({prev, cur}) inside
         4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_UP;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_DOWN;
         default:                            s = STEP_HOLD;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qdv_if.sv
// Handshake interfaces for the edge event and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface qdv_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic                       phase_sel;
   logic                       rising;
   logic [qdv_pkg::TS_W-1:0]   timestamp_ns;
   logic                       start_level_a;
   logic                       start_level_b;

   modport source (
      output valid, opcode, phase_sel, rising, timestamp_ns, start_level_a, start_level_b,
      input  ready
   );
   modport sink (
      input  valid, opcode, phase_sel, rising, timestamp_ns, start_level_a, start_level_b,
      output ready
   );
endinterface

interface qdv_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [qdv_pkg::OUT_W-1:0] angle_count;
   logic signed [qdv_pkg::OUT_W-1:0] velocity_steps;
   logic                             velocity_updated;

   modport source (
      output valid, angle_count, velocity_steps, velocity_updated,
      input  ready
   );
   modport sink (
      input  valid, angle_count, velocity_steps, velocity_updated,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/qdv_divider.sv
// Multiply by 1e9 in two partial products, then a restoring divide one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module qdv_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire qdv_pkg::div_cmd_type        cmd,
   input  wire logic [qdv_pkg::MAG_W-1:0]   mag,
   input  wire logic [qdv_pkg::REG_W-1:0]   divisor,
   output logic      [qdv_pkg::PROD_W-1:0]  quotient,
   output logic                             last
);
   import qdv_pkg::*;

   logic [PROD_W-1:0]     dq_ff, dq_in;
   logic [REG_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MAG_HALF_W-1:0] half;
   logic [PART_W-1:0]     part;
   logic [REG_W:0]        trial;
   logic                  fits;

   // Select the half of the magnitude for this partial product
   assign half = cmd.mul_hi ? mag[MAG_W-1:MAG_HALF_W] : mag[MAG_HALF_W-1:0];
   assign part = PART_W'(half) * PART_W'(NS_PER_SEC);

   // One restoring step: shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, dq_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      dq_in  = dq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.mul_lo) begin
         dq_in  = PROD_W'(part);
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.mul_hi) begin
         dq_in = dq_ff + (PROD_W'(part) << MAG_HALF_W);
      end else if (cmd.step) begin
         dq_in  = {dq_ff[PROD_W-2:0], fits};
         rem_in = fits ? REG_W'(trial - {1'b0, divisor}) : trial[REG_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign quotient = dq_ff;
   assign last     = cnt_ff == '1;

endmodule

`default_nettype wire

>>> hw/rtl/qdv_datapath.sv
// Decoder state, elapsed time check, velocity saturation and result register.
`timescale 1ns / 1ps
`default_nettype none

module qdv_datapath #(
   parameter int ANGLE_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire qdv_pkg::ctrl_cmd_type            cmd,
   output qdv_pkg::dp_status_type                status,
   input  wire logic                             csr_write_en,
   input  wire logic [qdv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [qdv_pkg::REG_W-1:0]        csr_write_data,
   input  wire logic                             req_opcode,
   input  wire logic                             req_phase_sel,
   input  wire logic                             req_rising,
   input  wire logic [qdv_pkg::TS_W-1:0]         req_timestamp_ns,
   input  wire logic                             req_start_level_a,
   input  wire logic                             req_start_level_b,
   output logic signed [qdv_pkg::OUT_W-1:0]      rsp_angle_count,
   output logic signed [qdv_pkg::OUT_W-1:0]      rsp_velocity_steps,
   output logic                                  rsp_velocity_updated
);
   import qdv_pkg::*;

   // Configuration
   logic [REG_W-1:0] min_ff, min_in;
   logic [REG_W-1:0] gap_ff, gap_in;

   // Captured beat
   logic            op_ff, sel_ff, rise_ff, lva_ff, lvb_ff;
   logic [TS_W-1:0] ts_ff;

   // Decoder state
   logic [1:0]             phase_ff, phase_in;
   logic [ANGLE_WIDTH-1:0] angle_ff, angle_in;
   logic [ANGLE_WIDTH-1:0] ref_angle_ff, ref_angle_in;
   logic [TS_W-1:0]        ref_time_ff, ref_time_in;
   logic [OUT_W-1:0]       vel_ff, vel_in;

   // Velocity job
   logic             upd_ff, neg_ff, big_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [REG_W-1:0] elapsed_ff;

   // Result register
   logic [OUT_W-1:0] out_angle_ff, out_vel_ff;
   logic             out_upd_ff;

   logic                   new_bit;
   logic [1:0]             cur;
   step_type               step;
   logic [ANGLE_WIDTH-1:0] angle_next, delta, mag_w;
   logic [TS_W:0]          diff;
   logic                   diff_pos, over_gap, upd_c;
   logic [REG_W-1:0]       elapsed_c;
   logic [PROD_W-1:0]      mag64, quotient;
   div_cmd_type            div_cmd;
   logic                   div_last;

   // Apply configuration writes
   always_comb begin
      min_in = min_ff;
      gap_in = gap_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_INTERVAL: min_in = csr_write_data;
            CSR_MAX_GAP:      gap_in = csr_write_data;
            default:          ;
         endcase
      end
   end

   // Phase update and angle step
   assign new_bit = ~rise_ff;
   assign cur     = sel_ff ? {phase_ff[1], new_bit} : {new_bit, phase_ff[0]};
   assign step    = qdv_step(phase_ff, cur);

   always_comb begin
      unique case (step)
         STEP_UP:   angle_next = angle_ff + ANGLE_WIDTH'(1);
         STEP_DOWN: angle_next = angle_ff - ANGLE_WIDTH'(1);
         default:   angle_next = angle_ff;
      endcase
   end

   // Elapsed time, limited to the gap; a negative time never updates
   assign diff      = {1'b0, ts_ff} - {1'b0, ref_time_ff};
   assign diff_pos  = ~diff[TS_W];
   assign over_gap  = diff[TS_W-1:0] > TS_W'(gap_ff);
   assign elapsed_c = over_gap ? gap_ff : diff[REG_W-1:0];
   assign upd_c     = (op_ff == OP_EDGE) && diff_pos && (elapsed_c > min_ff);

   // Signed angle change and its magnitude
   assign delta = angle_next - ref_angle_ff;
   assign mag_w = delta[ANGLE_WIDTH-1] ? (~delta + ANGLE_WIDTH'(1)) : delta;
   assign mag64 = PROD_W'(mag_w);

   // Advance the decoder state
   always_comb begin
      phase_in     = phase_ff;
      angle_in     = angle_ff;
      ref_angle_in = ref_angle_ff;
      ref_time_in  = ref_time_ff;
      vel_in       = vel_ff;
      if (cmd.calc) begin
         if (op_ff == OP_START) begin
            phase_in     = {~lva_ff, ~lvb_ff};
            angle_in     = '0;
            ref_angle_in = '0;
            ref_time_in  = ts_ff;
            vel_in       = '0;
         end else begin
            phase_in = cur;
            angle_in = angle_next;
            if (upd_c) begin
               ref_angle_in = angle_next;
               ref_time_in  = ts_ff;
            end
         end
      end else if (cmd.sat) begin
         // Saturate the quotient and restore the sign
         if (neg_ff) begin
            if (big_ff || quotient > POS_LIMIT) begin
               vel_in = VEL_NEG_MAX;
            end else begin
               vel_in = ~quotient[OUT_W-1:0] + OUT_W'(1);
            end
         end else begin
            if (big_ff || quotient > POS_LIMIT) begin
               vel_in = VEL_POS_MAX;
            end else begin
               vel_in = quotient[OUT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= MIN_INTERVAL_RESET;
         gap_ff       <= MAX_GAP_RESET;
         phase_ff     <= '0;
         angle_ff     <= '0;
         ref_angle_ff <= '0;
         ref_time_ff  <= '0;
         vel_ff       <= '0;
      end else begin
         min_ff       <= min_in;
         gap_ff       <= gap_in;
         phase_ff     <= phase_in;
         angle_ff     <= angle_in;
         ref_angle_ff <= ref_angle_in;
         ref_time_ff  <= ref_time_in;
         vel_ff       <= vel_in;
      end
   end

   // Capture the beat, the velocity job and the result
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff   <= req_opcode;
         sel_ff  <= req_phase_sel;
         rise_ff <= req_rising;
         ts_ff   <= req_timestamp_ns;
         lva_ff  <= req_start_level_a;
         lvb_ff  <= req_start_level_b;
      end
      if (cmd.calc) begin
         upd_ff     <= upd_c;
         neg_ff     <= delta[ANGLE_WIDTH-1];
         big_ff     <= mag64 > MAG_LIMIT;
         mag_ff     <= mag64[MAG_W-1:0];
         elapsed_ff <= elapsed_c;
      end
      if (cmd.load_rsp) begin
         out_angle_ff <= OUT_W'(angle_ff);
         out_vel_ff   <= vel_ff;
         out_upd_ff   <= upd_ff;
      end
   end

   assign div_cmd.mul_lo = cmd.mul_lo;
   assign div_cmd.mul_hi = cmd.mul_hi;
   assign div_cmd.step   = cmd.div_step;

   qdv_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .mag      (mag_ff),
      .divisor  (elapsed_ff),
      .quotient (quotient),
      .last     (div_last)
   );

   assign status.update   = upd_c;
   assign status.div_last = div_last;

   assign rsp_angle_count      = $signed(out_angle_ff);
   assign rsp_velocity_steps   = $signed(out_vel_ff);
   assign rsp_velocity_updated = out_upd_ff;

endmodule

`default_nettype wire

>>> hw/rtl/qdv_ctrl.sv
// Controller sequencing each beat: evaluate, multiply, divide, saturate, output.
`timescale 1ns / 1ps
`default_nettype none

module qdv_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire qdv_pkg::dp_status_type  status,
   output qdv_pkg::ctrl_cmd_type        cmd
);
   import qdv_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CALC   = 7'b0000010,
      S_MUL_LO = 7'b0000100,
      S_MUL_HI = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_SAT    = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = status.update ? S_MUL_LO : S_OUT;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            cmd.sat  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register is free
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/quadrature_decoder_with_velocity_core.sv
// Top level of the x4 quadrature decoder with velocity estimate.
//
// Edge events arrive as beats on req_chan: a start beat loads the phase levels
// and clears angle and velocity; an edge beat steps the angle and, once more
// than min_interval_ns has passed since the last update, recomputes velocity.
// Each beat gives exactly one result beat on rsp_chan.
// Registers are written through csr_write_en / csr_index / csr_write_data:
// index 0 is min_interval_ns, index 1 is max_gap_ns.
// Sequence: a beat that does not update velocity goes from evaluate straight
// to output; one that updates first passes through two partial-product
// multiplies, the 64-step restoring divider and saturation. One beat is in
// work at a time and the next is accepted in the cycle after the result is
// loaded.
// The result sits in an output register, so a new beat is accepted while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the block holds that result and accepts nothing until a slot frees.
// Reset clears angle, phase, references and velocity and restores register
// defaults; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_decoder_with_velocity_core #(
   parameter int ANGLE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   qdv_req_if.sink                             req_chan,
   qdv_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_write_en,
   input  wire logic [qdv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [qdv_pkg::REG_W-1:0]      csr_write_data
);
   import qdv_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   qdv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qdv_datapath #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_opcode           (req_chan.opcode),
      .req_phase_sel        (req_chan.phase_sel),
      .req_rising           (req_chan.rising),
      .req_timestamp_ns     (req_chan.timestamp_ns),
      .req_start_level_a    (req_chan.start_level_a),
      .req_start_level_b    (req_chan.start_level_b),
      .rsp_angle_count      (rsp_chan.angle_count),
      .rsp_velocity_steps   (rsp_chan.velocity_steps),
      .rsp_velocity_updated (rsp_chan.velocity_updated)
   );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the quadrature decoder core, checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import qdv_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 100;
   localparam int REPORT_LIMIT   = 10;

   // Angle step decode, indexed by {old inverted pins, new inverted pins}
   localparam logic [15:0] STEP_UP_MAP   = 16'h4182;
   localparam logic [15:0] STEP_DOWN_MAP = 16'h2814;
   localparam logic [63:0] NS_PER_S      = 64'd1000000000;

   typedef struct packed {
      logic            op;
      logic            phase_sel;
      logic            rising;
      logic [TS_W-1:0] ts;
      logic            level_a;
      logic            level_b;
   } edge_beat_type;

   typedef struct packed {
      logic [OUT_W-1:0] angle;
      logic [OUT_W-1:0] velocity;
      logic             updated;
   } motion_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_op = 1'b0;
   logic                 req_phase_sel = 1'b0;
   logic                 req_rising = 1'b0;
   logic [TS_W-1:0]      req_ts = '0;
   logic                 req_level_a = 1'b0;
   logic                 req_level_b = 1'b0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = CSR_MIN_INTERVAL;
   logic [REG_W-1:0]     csr_data = '0;

   qdv_req_if req_if ();
   qdv_rsp_if rsp_if ();

   assign req_if.valid         = req_valid;
   assign req_if.opcode        = req_op;
   assign req_if.phase_sel     = req_phase_sel;
   assign req_if.rising        = req_rising;
   assign req_if.timestamp_ns  = req_ts;
   assign req_if.start_level_a = req_level_a;
   assign req_if.start_level_b = req_level_b;
   assign rsp_if.ready         = rsp_ready;

   quadrature_decoder_with_velocity_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_we),
      .csr_index      (csr_idx),
      .csr_write_data (csr_data)
   );

   // Beats waiting to be offered and results still owed by the core
   edge_beat_type pending_beats[$];
   motion_type    motion_q[$];
   edge_beat_type drive_beat;
   edge_beat_type seen_beat;
   motion_type    want;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;

   // Predictor state and register copies
   logic [1:0]       inv_pins;
   logic [OUT_W-1:0] angle_now;
   logic [OUT_W-1:0] angle_ref;
   logic [TS_W-1:0]  time_ref;
   logic [OUT_W-1:0] vel_now;
   logic [REG_W-1:0] min_iv_ns;
   logic [REG_W-1:0] gap_lim_ns;

   // Stimulus generator state: pin levels as sent, running time, direction
   logic            pin_a = 1'b1;
   logic            pin_b = 1'b1;
   logic [TS_W-1:0] now_ns = '0;
   logic            run_down = 1'b0;

   function automatic logic [OUT_W-1:0] steps_per_sec(input logic [OUT_W-1:0] delta,
                                                      input logic [63:0] span);
      logic [63:0] mag;
      logic [63:0] q;
      mag = delta[OUT_W-1] ? (64'd0 - {{32{delta[OUT_W-1]}}, delta}) : {32'd0, delta};
      q = (mag * NS_PER_S) / span;
      if (delta[OUT_W-1]) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         q = 64'd0 - q;
         return q[OUT_W-1:0];
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[OUT_W-1:0];
   endfunction

   function automatic motion_type track_motion(input edge_beat_type b);
      motion_type         m;
      logic [1:0]         nxt;
      logic signed [63:0] span;
      logic signed [63:0] lim;
      m.updated = 1'b0;
      if (b.op == OP_START) begin
         inv_pins  = {~b.level_a, ~b.level_b};
         angle_now = '0;
         angle_ref = '0;
         time_ref  = b.ts;
         vel_now   = '0;
      end else begin
         nxt = b.phase_sel ? {inv_pins[1], ~b.rising} : {~b.rising, inv_pins[0]};
         if (STEP_UP_MAP[{inv_pins, nxt}]) begin
            angle_now = angle_now + 1'b1;
         end else if (STEP_DOWN_MAP[{inv_pins, nxt}]) begin
            angle_now = angle_now - 1'b1;
         end
         inv_pins = nxt;
         // Both stamps sit below 2^63, so the difference fits in 64 bits
         span = $signed({1'b0, b.ts}) - $signed({1'b0, time_ref});
         lim  = $signed({33'd0, gap_lim_ns});
         if (span > lim) begin
            span = lim;
         end else if (span < -lim) begin
            span = -lim;
         end
         if (span > $signed({33'd0, min_iv_ns})) begin
            vel_now   = steps_per_sec(angle_now - angle_ref, span);
            angle_ref = angle_now;
            time_ref  = b.ts;
            m.updated = 1'b1;
         end
      end
      m.angle    = angle_now;
      m.velocity = vel_now;
      return m;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer queued beats, idling at random between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_if.ready) begin
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_beat     = pending_beats.pop_front();
            req_op        <= drive_beat.op;
            req_phase_sel <= drive_beat.phase_sel;
            req_rising    <= drive_beat.rising;
            req_ts        <= drive_beat.ts;
            req_level_a   <= drive_beat.level_a;
            req_level_b   <= drive_beat.level_b;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Track register writes and accepted beats, check results
   always @(posedge clock) begin
      if (reset) begin
         inv_pins   = 2'b00;
         angle_now  = '0;
         angle_ref  = '0;
         time_ref   = '0;
         vel_now    = '0;
         min_iv_ns  = MIN_INTERVAL_RESET;
         gap_lim_ns = MAX_GAP_RESET;
      end else begin
         if (csr_we) begin
            if (csr_idx == CSR_MIN_INTERVAL) begin
               min_iv_ns = csr_data;
            end else if (csr_idx == CSR_MAX_GAP) begin
               gap_lim_ns = csr_data;
            end
         end
         if (req_if.valid && req_if.ready) begin
            seen_beat.op        = req_if.opcode;
            seen_beat.phase_sel = req_if.phase_sel;
            seen_beat.rising    = req_if.rising;
            seen_beat.ts        = req_if.timestamp_ns;
            seen_beat.level_a   = req_if.start_level_a;
            seen_beat.level_b   = req_if.start_level_b;
            motion_q.push_back(track_motion(seen_beat));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (motion_q.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("unexpected result beat: angle %0d velocity %0d updated %0b",
                           $signed(rsp_if.angle_count), $signed(rsp_if.velocity_steps),
                           rsp_if.velocity_updated);
               end
               mismatches++;
            end else begin
               want = motion_q.pop_front();
               if (rsp_if.angle_count !== want.angle ||
                   rsp_if.velocity_steps !== want.velocity ||
                   rsp_if.velocity_updated !== want.updated) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display({"result mismatch at %0t: angle %0d exp %0d, ",
                               "velocity %0d exp %0d, updated %0b exp %0b"},
                              $realtime, $signed(rsp_if.angle_count), $signed(want.angle),
                              $signed(rsp_if.velocity_steps), $signed(want.velocity),
                              rsp_if.velocity_updated, want.updated);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   // Hold off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // End the run if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_beat(input logic op, input logic sel, input logic rising,
                             input logic [TS_W-1:0] ts, input logic la, input logic lb);
      edge_beat_type b;
      b.op        = op;
      b.phase_sel = sel;
      b.rising    = rising;
      b.ts        = ts;
      b.level_a   = la;
      b.level_b   = lb;
      pending_beats.push_back(b);
   endtask

   // Mostly clean quadrature runs, with starts, stray edges and time jumps mixed in
   task automatic queue_motion(input int n, input int unsigned scale);
      edge_beat_type b;
      logic [63:0]   wide;
      int unsigned   roll;
      for (int i = 0; i < n; i++) begin
         wide        = {$urandom, $urandom};
         b.op        = OP_EDGE;
         b.phase_sel = wide[0];
         b.rising    = wide[1];
         b.level_a   = wide[2];
         b.level_b   = wide[3];
         roll = $urandom_range(0, 9);
         if (roll < 6) begin
            now_ns = now_ns + TS_W'($urandom_range(0, scale));
         end else if (roll < 9) begin
            now_ns = now_ns + TS_W'($urandom_range(scale, 4 * scale));
         end else begin
            now_ns = now_ns + TS_W'($urandom);
         end
         b.ts = now_ns;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            b.op  = OP_START;
            pin_a = b.level_a;
            pin_b = b.level_b;
         end else if (roll < 8) begin
            // Stray edge: may leave its phase where it was
            if (b.phase_sel) begin
               pin_b = b.rising;
            end else begin
               pin_a = b.rising;
            end
         end else begin
            if (roll < 10) begin
               b.ts = now_ns - TS_W'($urandom);
            end else if (roll < 11) begin
               wide   = {$urandom, $urandom};
               now_ns = wide[TS_W-1:0];
               b.ts   = now_ns;
            end
            if ($urandom_range(0, 19) == 0) run_down = ~run_down;
            if ((pin_a == pin_b) ^ run_down) begin
               pin_b       = ~pin_b;
               b.phase_sel = 1'b1;
               b.rising    = pin_b;
            end else begin
               pin_a       = ~pin_a;
               b.phase_sel = 1'b0;
               b.rising    = pin_a;
            end
         end
         pending_beats.push_back(b);
      end
   endtask

   // Wait until every queued beat is accepted and every result is back
   task automatic drain();
      @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || motion_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      @(posedge clock);
      csr_we   <= 1'b1;
      csr_idx  <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_we   <= 1'b0;
   endtask

   task automatic set_phase(input logic [REG_W-1:0] min_iv, input logic [REG_W-1:0] gap,
                            input int idle_pct, input int stall_pct);
      drain();
      write_reg(CSR_MIN_INTERVAL, min_iv);
      write_reg(CSR_MAX_GAP, gap);
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset register values, edges before any start
      queue_beat(OP_EDGE, 1'b1, 1'b1, 63'd0, 1'b0, 1'b0);
      queue_beat(OP_EDGE, 1'b0, 1'b0, 63'd2000000, 1'b1, 1'b1);
      // Start with ignored edge fields set, then four steps up
      queue_beat(OP_START, 1'b1, 1'b1, 63'd10, 1'b0, 1'b0);
      queue_beat(OP_EDGE, 1'b1, 1'b1, 63'd300010, 1'b1, 1'b0);
      queue_beat(OP_EDGE, 1'b0, 1'b1, 63'd600010, 1'b0, 1'b1);
      queue_beat(OP_EDGE, 1'b1, 1'b0, 63'd900010, 1'b1, 1'b1);
      queue_beat(OP_EDGE, 1'b0, 1'b0, 63'd1200010, 1'b0, 1'b0);
      // Stamp earlier than the reference, then the latest possible stamp
      queue_beat(OP_EDGE, 1'b1, 1'b1, 63'd5, 1'b0, 1'b1);
      queue_beat(OP_EDGE, 1'b0, 1'b1, {TS_W{1'b1}}, 1'b1, 1'b0);
      queue_beat(OP_START, 1'b0, 1'b0, {TS_W{1'b1}}, 1'b1, 1'b1);
      queue_beat(OP_EDGE, 1'b0, 1'b0, 63'd0, 1'b0, 1'b0);
      // Edge that leaves its phase unchanged
      queue_beat(OP_EDGE, 1'b0, 1'b0, 63'd1, 1'b1, 1'b1);
      // Steps down, straddling the interval boundary
      queue_beat(OP_START, 1'b0, 1'b0, 63'd1000, 1'b1, 1'b0);
      queue_beat(OP_EDGE, 1'b1, 1'b1, 63'd1100, 1'b0, 1'b0);
      queue_beat(OP_EDGE, 1'b0, 1'b0, 63'd1200, 1'b1, 1'b1);
      queue_beat(OP_EDGE, 1'b1, 1'b0, 63'd1300, 1'b0, 1'b1);
      queue_beat(OP_EDGE, 1'b0, 1'b1, 63'd1400, 1'b1, 1'b0);
      queue_beat(OP_EDGE, 1'b1, 1'b1, 63'd1001000, 1'b0, 1'b0);
      queue_beat(OP_EDGE, 1'b0, 1'b0, 63'd1001001, 1'b1, 1'b1);
      queue_beat(OP_EDGE, 1'b1, 1'b0, 63'd1001001, 1'b0, 1'b1);
      queue_beat(OP_START, 1'b1, 1'b0, 63'd123456789, 1'b0, 1'b1);
      pin_a  = 1'b0;
      pin_b  = 1'b1;
      now_ns = 63'd123456789;

      // Every positive interval updates; hold the receiver off mid-stream
      set_phase(31'd0, 31'd2147483647, 0, 0);
      queue_motion(200, 4);
      @(posedge clock);
      hold_requests <= hold_requests + 1;

      // Sender idles; pause until every result is back halfway through
      set_phase(31'd1000, 31'd2000000000, 49, 0);
      queue_motion(100, 400);
      drain();
      queue_motion(100, 400);

      // Large minimum interval and largest gap, receiver stalls
      set_phase(31'd2000000000, 31'd2147483647, 0, 49);
      queue_motion(150, 600000000);

      // Gap of one: elapsed time clamps to one, velocity may saturate
      set_phase(31'd0, 31'd1, 31, 31);
      queue_motion(150, 4);

      // Zero gap: velocity never updates
      set_phase(31'd7, 31'd0, 31, 31);
      queue_motion(80, 10);

      // Gap limit above typical steps, below the rare large jumps
      set_phase(31'd500000, 31'd3000000, 31, 31);
      queue_motion(220, 400000);

      // Back to the reset values
      set_phase(MIN_INTERVAL_RESET, MAX_GAP_RESET, 0, 0);
      queue_motion(200, 300000);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && motion_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
